>>> hw/rtl/ffc_param_row_interpolator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion shorthands for the row interpolator RTL.
// ----------------------------------------------------------------------------
`ifndef FFC_PARAM_ROW_INTERPOLATOR_MACROS_SVH
`define FFC_PARAM_ROW_INTERPOLATOR_MACROS_SVH

// same-cycle implication, clock and reset are the house names
`define FFC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FFC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/ffc_pkg.sv
// ----------------------------------------------------------------------------
// ffc_pkg
// Types and constants of the flat-field parameter row interpolator.
// ----------------------------------------------------------------------------
package ffc_pkg;

   localparam int MAX_BLOCKS_PER_ROW = 64;
   localparam int MAX_BLOCK_ROWS     = 64;

   localparam int WORD_W   = 24;
   localparam int GAIN_W   = 13;
   localparam int OFS_W    = 11;
   localparam int CFG_W    = 7;
   localparam int CSR_W    = 32;
   localparam int CSR_AW   = 3;

   localparam int MAX_PICKED = (MAX_BLOCKS_PER_ROW + 1) / 2;
   localparam int COL_W = ($clog2(MAX_PICKED) > 0) ? $clog2(MAX_PICKED) : 1;
   localparam int ROW_W = ($clog2(MAX_BLOCK_ROWS) > 0) ? $clog2(MAX_BLOCK_ROWS) : 1;
   localparam int CMP_W = ((COL_W > ROW_W) ? COL_W : ROW_W) + CFG_W;

   localparam logic [CFG_W-1:0] BPR_RESET  = CFG_W'(25);
   localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(18);

   // register index, taken from paddr bit 2
   localparam logic REG_BLOCKS_PER_ROW = 1'b0;
   localparam logic REG_BLOCK_ROWS     = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = ($clog2(QUEUE_DEPTH) > 0) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // result slots of one step, emitted lowest first
   localparam int SLOT_PREV = 0;
   localparam int SLOT_MID  = 1;
   localparam int SLOT_DUP  = 2;
   localparam int SLOT_TAIL = 3;
   localparam int SLOT_N    = 4;

   typedef struct packed {
      logic [WORD_W-1:0] prev_word;
      logic [WORD_W-1:0] mid_word;
      logic [WORD_W-1:0] cur_word;
      logic [SLOT_N-1:0] emit_mask;
      logic              last_row;
   } desc_type;

   function automatic logic [CFG_W-1:0] clamp_reg(input logic [CFG_W-1:0] v, input int maxv);
      logic [CFG_W-1:0] r;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (int'(v) > maxv) begin
         r = CFG_W'(maxv);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] midpoint(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
      logic [GAIN_W:0] gsum;
      logic [OFS_W:0]  osum;
      logic [OFS_W:0]  oadj;
      gsum = {1'b0, a[WORD_W-1:OFS_W]} + {1'b0, b[WORD_W-1:OFS_W]};
      osum = {a[OFS_W-1], a[OFS_W-1:0]} + {b[OFS_W-1], b[OFS_W-1:0]};
      // round toward zero: bias negative sums by one before the shift
      oadj = osum + {{OFS_W{1'b0}}, osum[OFS_W]};
      return {gsum[GAIN_W:1], oadj[OFS_W:1]};
   endfunction

endpackage

>>> hw/rtl/ffc_param_row_interpolator.sv
// ----------------------------------------------------------------------------
// ffc_param_row_interpolator
// Expands half-sampled flat-field parameter rows to full row width.
// ----------------------------------------------------------------------------
// Input queue port: drive req_sampled_param with push while full is low; one
// word is taken per cycle. Result queue port: while empty is low the oldest
// result sits on rsp_block_param and its flags; pop takes it.
// Each sampled word yields zero to four results: none for the first word of
// a row (unless the row has one sample), the stored word and the midpoint for
// later words, and one or two copies of the row's last word at the row end.
// Results leave at one beat per cycle while pop is held high; a row of B
// blocks yields B results, all passing the single output register of the
// back end. When the back end is idle, the first result of a word passes
// the queue entry, the back end's step register and the output register
// before it is visible on rsp_block_param.
// A four-entry descriptor queue decouples input and output; when pop is held
// low the queue fills and full rises, nothing is dropped.
// Reset clears counters, stored word and queues; blocks_per_row returns to 25
// and block_rows to 18. Registers: blocks_per_row at 0x0, block_rows at 0x4.
// ----------------------------------------------------------------------------
module ffc_param_row_interpolator import ffc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [WORD_W-1:0] req_sampled_param,
   output logic              empty,
   input  logic              pop,
   output logic [WORD_W-1:0] rsp_block_param,
   output logic              rsp_row_end,
   output logic              rsp_frame_end,
   output logic              rsp_step_last,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_W-1:0]  pwdata,
   output logic [CSR_W-1:0]  prdata,
   output logic              pready
);

   logic [CFG_W-1:0] bpr_ff, bpr_in, rows_ff, rows_in;
   logic             wr_en;
   logic             fq_push, q_full, q_pop, q_empty;
   desc_type         fq_desc, q_head;

   always_comb begin
      pready  = 1'b1;
      wr_en   = psel && penable && pwrite;
      bpr_in  = bpr_ff;
      rows_in = rows_ff;
      if (wr_en && (paddr[2] == REG_BLOCKS_PER_ROW)) begin
         bpr_in = pwdata[CFG_W-1:0];
      end
      if (wr_en && (paddr[2] == REG_BLOCK_ROWS)) begin
         rows_in = pwdata[CFG_W-1:0];
      end
      case (paddr[2])
         REG_BLOCKS_PER_ROW: prdata = CSR_W'(bpr_ff);
         REG_BLOCK_ROWS:     prdata = CSR_W'(rows_ff);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpr_ff  <= BPR_RESET;
         rows_ff <= ROWS_RESET;
      end else begin
         bpr_ff  <= bpr_in;
         rows_ff <= rows_in;
      end
   end

   assign full = q_full;

   ffc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .blocks_per_row (bpr_ff),
      .block_rows     (rows_ff),
      .push           (push),
      .word           (req_sampled_param),
      .q_full         (q_full),
      .q_push         (fq_push),
      .q_desc         (fq_desc)
   );

   ffc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_desc (fq_desc),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   ffc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_head      (q_head),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .pop         (pop),
      .empty       (empty),
      .block_param (rsp_block_param),
      .row_end     (rsp_row_end),
      .frame_end   (rsp_frame_end),
      .step_last   (rsp_step_last)
   );

endmodule

>>> hw/rtl/ffc_front.sv
// ----------------------------------------------------------------------------
// ffc_front
// Accepts sampled words, tracks column and row, builds one step descriptor.
// ----------------------------------------------------------------------------
module ffc_front import ffc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [CFG_W-1:0]  blocks_per_row,
   input  logic [CFG_W-1:0]  block_rows,
   input  logic              push,
   input  logic [WORD_W-1:0] word,
   input  logic              q_full,
   output logic              q_push,
   output desc_type          q_desc
);

   logic [WORD_W-1:0] prev_ff, prev_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   logic [CFG_W-1:0]  nb, nr, picked;
   logic [CFG_W:0]    nb_inc;
   logic              accept, last_col, last_row, pair;

   always_comb begin
      nb       = clamp_reg(blocks_per_row, MAX_BLOCKS_PER_ROW);
      nr       = clamp_reg(block_rows, MAX_BLOCK_ROWS);
      nb_inc   = {1'b0, nb} + (CFG_W+1)'(1);
      picked   = nb_inc[CFG_W:1];
      last_col = CMP_W'(col_ff) >= (CMP_W'(picked) - CMP_W'(1));
      last_row = CMP_W'(row_ff) >= (CMP_W'(nr) - CMP_W'(1));
      pair     = col_ff != '0;
      accept   = push && !q_full;

      q_push = accept && (pair || last_col);
      q_desc.prev_word = prev_ff;
      q_desc.mid_word  = midpoint(prev_ff, word);
      q_desc.cur_word  = word;
      q_desc.emit_mask = '0;
      q_desc.emit_mask[SLOT_PREV] = pair;
      q_desc.emit_mask[SLOT_MID]  = pair;
      q_desc.emit_mask[SLOT_DUP]  = last_col && !nb[0];
      q_desc.emit_mask[SLOT_TAIL] = last_col;
      q_desc.last_row  = last_row;

      prev_in = prev_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         prev_in = word;
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         prev_ff <= prev_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

endmodule

>>> hw/rtl/ffc_queue.sv
// ----------------------------------------------------------------------------
// ffc_queue
// Short descriptor queue between front and back.
// ----------------------------------------------------------------------------
module ffc_queue import ffc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   output logic     full,
   input  logic     pop,
   output desc_type head,
   output logic     empty
);

`include "ffc_param_row_interpolator_macros.svh"

   desc_type          q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   always_comb begin
      full    = cnt_ff == QCNT_W'(QUEUE_DEPTH);
      empty   = cnt_ff == '0;
      head    = q_ff[rd_ff];
      do_push = push && !full;
      do_pop  = pop && !empty;
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      cnt_in  = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ff] <= push_desc;
      end
   end

   `FFC_ASSERT_IMPL(a_no_push_full, push, !full, "descriptor pushed into full queue")
   `FFC_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_ff <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")

endmodule

>>> hw/rtl/ffc_back.sv
// ----------------------------------------------------------------------------
// ffc_back
// Walks the result slots of each descriptor, one beat per cycle while pop keeps the output register free.
// ----------------------------------------------------------------------------
module ffc_back import ffc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  desc_type          q_head,
   input  logic              q_empty,
   output logic              q_pop,
   input  logic              pop,
   output logic              empty,
   output logic [WORD_W-1:0] block_param,
   output logic              row_end,
   output logic              frame_end,
   output logic              step_last
);

`include "ffc_param_row_interpolator_macros.svh"

   desc_type          cur_ff, cur_in;
   logic [SLOT_N-1:0] mask_ff, mask_in, sel, rem;
   logic              out_valid_ff, out_valid_in;
   logic [WORD_W-1:0] out_word_ff, out_word_in;
   logic              out_row_end_ff, out_row_end_in;
   logic              out_frame_end_ff, out_frame_end_in;
   logic              out_step_last_ff, out_step_last_in;
   logic              pop_ok, slot_free, emit, need_load;

   always_comb begin
      pop_ok    = pop && out_valid_ff;
      slot_free = !out_valid_ff || pop_ok;
      emit      = slot_free && (mask_ff != '0);
      sel       = mask_ff & (~mask_ff + SLOT_N'(1));
      rem       = mask_ff & ~sel;
      need_load = (mask_ff == '0) || (emit && (rem == '0));
      q_pop     = need_load && !q_empty;

      cur_in  = q_pop ? q_head : cur_ff;
      mask_in = mask_ff;
      if (q_pop) begin
         mask_in = q_head.emit_mask;
      end else if (emit) begin
         mask_in = rem;
      end

      out_valid_in     = out_valid_ff && !pop_ok;
      out_word_in      = out_word_ff;
      out_row_end_in   = out_row_end_ff;
      out_frame_end_in = out_frame_end_ff;
      out_step_last_in = out_step_last_ff;
      if (emit) begin
         out_valid_in     = 1'b1;
         out_row_end_in   = sel[SLOT_TAIL];
         out_frame_end_in = sel[SLOT_TAIL] && cur_ff.last_row;
         out_step_last_in = rem == '0;
         if (sel[SLOT_PREV]) begin
            out_word_in = cur_ff.prev_word;
         end else if (sel[SLOT_MID]) begin
            out_word_in = cur_ff.mid_word;
         end else begin
            out_word_in = cur_ff.cur_word;
         end
      end

      empty       = !out_valid_ff;
      block_param = out_word_ff;
      row_end     = out_row_end_ff;
      frame_end   = out_frame_end_ff;
      step_last   = out_step_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff           <= cur_in;
      out_word_ff      <= out_word_in;
      out_row_end_ff   <= out_row_end_in;
      out_frame_end_ff <= out_frame_end_in;
      out_step_last_ff <= out_step_last_in;
   end

   `FFC_ASSERT_IMPL(a_row_end_last, out_valid_ff && out_row_end_ff, out_step_last_ff, "row end not last of step")
   `FFC_ASSERT_IMPL(a_frame_in_row, out_valid_ff && out_frame_end_ff, out_row_end_ff, "frame end without row end")

endmodule
